@@ rtl/qrm_pkg.sv @@
// Shared constants and types for the quaternion to rotation matrix block.
// Used by the channel interfaces and the top level; no dependencies.
package qrm_pkg;

    // Component width and fixed-point layout (signed Q1.(COMP_WIDTH-1))
    localparam int COMP_WIDTH = 16;
    localparam int FRAC       = COMP_WIDTH - 1;
    localparam int LOW_SHIFT  = FRAC - 1;
    localparam int PROD_W     = 2 * COMP_WIDTH;
    localparam int ACC_W      = 2 * COMP_WIDTH + 2;

    localparam int N_PROD = 9;
    localparam int N_ELEM = 9;

    typedef logic signed [COMP_WIDTH-1:0] t_comp;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [ACC_W-1:0]      t_acc;

    // Rounding offset, unit value and saturation limits at accumulator width
    localparam t_acc HALF    = t_acc'(1) <<< (LOW_SHIFT - 1);
    localparam t_acc ONE     = t_acc'(1) <<< FRAC;
    localparam t_acc MAX_VAL = (t_acc'(1) <<< FRAC) - t_acc'(1);
    localparam t_acc MIN_VAL = -(t_acc'(1) <<< FRAC);

    // Product slots
    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_XY = 3;
    localparam int P_XZ = 4;
    localparam int P_YZ = 5;
    localparam int P_WX = 6;
    localparam int P_WY = 7;
    localparam int P_WZ = 8;

    // Matrix entry slots, row-major
    localparam int E_00 = 0;
    localparam int E_01 = 1;
    localparam int E_02 = 2;
    localparam int E_10 = 3;
    localparam int E_11 = 4;
    localparam int E_12 = 5;
    localparam int E_20 = 6;
    localparam int E_21 = 7;
    localparam int E_22 = 8;

    // Diagonal entries carry the unit offset
    localparam logic [N_ELEM-1:0] DIAG_MASK =
        (N_ELEM'(1) << E_00) | (N_ELEM'(1) << E_11) | (N_ELEM'(1) << E_22);

endpackage

@@ rtl/qrm_quat_if.sv @@
// Input channel: one quaternion per transaction, valid/ready handshake.
// Depends on qrm_pkg for the component type.
interface qrm_quat_if;
    import qrm_pkg::*;

    logic  valid;
    logic  ready;
    t_comp quat_w;
    t_comp quat_x;
    t_comp quat_y;
    t_comp quat_z;

    modport source (output valid, output quat_w, output quat_x, output quat_y,
                    output quat_z, input ready);
    modport sink   (input valid, input quat_w, input quat_x, input quat_y,
                    input quat_z, output ready);
endinterface

@@ rtl/qrm_mat_if.sv @@
// Output channel: nine rotation matrix entries per transaction, valid/ready.
// Depends on qrm_pkg for the component type.
interface qrm_mat_if;
    import qrm_pkg::*;

    logic  valid;
    logic  ready;
    t_comp elem_00;
    t_comp elem_01;
    t_comp elem_02;
    t_comp elem_10;
    t_comp elem_11;
    t_comp elem_12;
    t_comp elem_20;
    t_comp elem_21;
    t_comp elem_22;

    modport source (output valid, output elem_00, output elem_01, output elem_02,
                    output elem_10, output elem_11, output elem_12,
                    output elem_20, output elem_21, output elem_22, input ready);
    modport sink   (input valid, input elem_00, input elem_01, input elem_02,
                    input elem_10, input elem_11, input elem_12,
                    input elem_20, input elem_21, input elem_22, output ready);
endinterface

@@ rtl/quaternion_to_rotation_matrix.sv @@
// Quaternion to 3x3 rotation matrix, three-stage pipeline (products, pair sums
// with rounding offset, shift/offset/saturate into the output register).
// Throughput: one transaction per cycle; each stage holds under back-pressure.
// Reset (i_rst_n low, synchronous) clears the stage valid bits only.
// Depends on qrm_pkg, qrm_quat_if and qrm_mat_if.
module quaternion_to_rotation_matrix (
    input  logic          i_clk,
    input  logic          i_rst_n,
    qrm_quat_if.sink      i_quat,
    qrm_mat_if.source     o_mat
);
    import qrm_pkg::*;

    // Stage valid bits and advance enables
    logic r_v1, r_v2, r_v3;
    logic w_adv1, w_adv2, w_adv3;

    // Stage payloads
    t_prod r_prod [N_PROD];
    t_prod n_prod [N_PROD];
    t_acc  r_rnd  [N_ELEM];
    t_acc  n_rnd  [N_ELEM];
    t_comp r_elem [N_ELEM];
    t_comp n_elem [N_ELEM];

    // A stage takes new data when it is empty or its contents move on
    assign w_adv3       = !r_v3 || o_mat.ready;
    assign w_adv2       = !r_v2 || w_adv3;
    assign w_adv1       = !r_v1 || w_adv2;
    assign i_quat.ready = w_adv1;

    // Stage 1: the nine component products, operands widened to full product width
    always_comb begin
        n_prod[P_XX] = t_prod'(i_quat.quat_x) * t_prod'(i_quat.quat_x);
        n_prod[P_YY] = t_prod'(i_quat.quat_y) * t_prod'(i_quat.quat_y);
        n_prod[P_ZZ] = t_prod'(i_quat.quat_z) * t_prod'(i_quat.quat_z);
        n_prod[P_XY] = t_prod'(i_quat.quat_x) * t_prod'(i_quat.quat_y);
        n_prod[P_XZ] = t_prod'(i_quat.quat_x) * t_prod'(i_quat.quat_z);
        n_prod[P_YZ] = t_prod'(i_quat.quat_y) * t_prod'(i_quat.quat_z);
        n_prod[P_WX] = t_prod'(i_quat.quat_w) * t_prod'(i_quat.quat_x);
        n_prod[P_WY] = t_prod'(i_quat.quat_w) * t_prod'(i_quat.quat_y);
        n_prod[P_WZ] = t_prod'(i_quat.quat_w) * t_prod'(i_quat.quat_z);
    end

    // Stage 2: signed pair sums plus half an LSB of the result; diagonals negate
    always_comb begin
        n_rnd[E_00] = HALF - t_acc'(r_prod[P_YY]) - t_acc'(r_prod[P_ZZ]);
        n_rnd[E_01] = HALF + t_acc'(r_prod[P_XY]) + t_acc'(r_prod[P_WZ]);
        n_rnd[E_02] = HALF + t_acc'(r_prod[P_XZ]) - t_acc'(r_prod[P_WY]);
        n_rnd[E_10] = HALF + t_acc'(r_prod[P_XY]) - t_acc'(r_prod[P_WZ]);
        n_rnd[E_11] = HALF - t_acc'(r_prod[P_XX]) - t_acc'(r_prod[P_ZZ]);
        n_rnd[E_12] = HALF + t_acc'(r_prod[P_YZ]) + t_acc'(r_prod[P_WX]);
        n_rnd[E_20] = HALF + t_acc'(r_prod[P_XZ]) + t_acc'(r_prod[P_WY]);
        n_rnd[E_21] = HALF + t_acc'(r_prod[P_YZ]) - t_acc'(r_prod[P_WX]);
        n_rnd[E_22] = HALF - t_acc'(r_prod[P_XX]) - t_acc'(r_prod[P_YY]);
    end

    // Stage 3: drop the low bits (floor), add one on the diagonal, saturate
    always_comb begin
        t_acc v_q;
        for (int k = 0; k < N_ELEM; k++) begin
            v_q = r_rnd[k] >>> LOW_SHIFT;
            if (DIAG_MASK[k]) begin
                v_q = v_q + ONE;
            end
            if (v_q > MAX_VAL) begin
                n_elem[k] = MAX_VAL[COMP_WIDTH-1:0];
            end else if (v_q < MIN_VAL) begin
                n_elem[k] = MIN_VAL[COMP_WIDTH-1:0];
            end else begin
                n_elem[k] = v_q[COMP_WIDTH-1:0];
            end
        end
    end

    // Valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_quat.valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Payload registers: load on advance with valid data, hold otherwise
    always_ff @(posedge i_clk) begin
        if (w_adv1 && i_quat.valid) begin
            r_prod <= n_prod;
        end
        if (w_adv2 && r_v1) begin
            r_rnd <= n_rnd;
        end
        if (w_adv3 && r_v2) begin
            r_elem <= n_elem;
        end
    end

    // Output transaction
    assign o_mat.valid   = r_v3;
    assign o_mat.elem_00 = r_elem[E_00];
    assign o_mat.elem_01 = r_elem[E_01];
    assign o_mat.elem_02 = r_elem[E_02];
    assign o_mat.elem_10 = r_elem[E_10];
    assign o_mat.elem_11 = r_elem[E_11];
    assign o_mat.elem_12 = r_elem[E_12];
    assign o_mat.elem_20 = r_elem[E_20];
    assign o_mat.elem_21 = r_elem[E_21];
    assign o_mat.elem_22 = r_elem[E_22];

    // An accepted transaction occupies stage 1 on the next cycle
    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_quat.valid && i_quat.ready |=> r_v1)
        else $error("accepted transaction not held in stage 1");

    // A full pipeline stalled at the output must refuse new input
    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 && r_v2 && r_v3 && !o_mat.ready |-> !i_quat.ready)
        else $error("input accepted while pipeline full and stalled");

    // A stage-2 item blocked at the output stays in stage 2
    a_s2_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 && r_v3 && !o_mat.ready |=> r_v2)
        else $error("stage 2 item lost under back-pressure");

endmodule
